/* sv/rvig_pkg.sv */
// Shared constants, register codes and width helpers for the radial vignette pixel block.
// Used by every module of the block. It has no dependencies of its own.
`timescale 1ns / 1ps

package rvig_pkg;

    // These field widths are set by the pixel and register formats.
    localparam int COORD_W   = 12;
    localparam int CHAN_W    = 8;
    localparam int CFG_DIM_W = 13;
    localparam int STR_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // The offset magnitude |2*pos - dim| always fits in one bit more than a coordinate.
    localparam int MAG_W = COORD_W + 1;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int R2_W  = SQ_W + 1;

    // The strength is Q4.12 and the factor is Q1.16. Scaling by 16 lifts the strength to Q.16.
    localparam int FRAC_W    = 16;
    localparam int STR_SHIFT = 4;
    localparam int QUO_W     = FRAC_W;
    localparam int FAC_W     = FRAC_W + 1;
    localparam int NUM_W     = STR_W + R2_W + STR_SHIFT;

    localparam logic [FAC_W-1:0] FACTOR_ONE    = FAC_W'(1) << FRAC_W;
    localparam logic [STR_W-1:0] BYPASS_BELOW  = STR_W'(5);
    localparam int               MAX_DIM_DEF   = 4096;

    // These are the configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = CFG_IDX_W'(2);

    // This gives the width of a clamped image dimension. A register value never exceeds 8191.
    function automatic int dim_width(input int max_dim);
        int w;
        begin
            if (max_dim >= (1 << CFG_DIM_W) - 1)
            begin
                w = CFG_DIM_W;
            end
            else
            begin
                w = $clog2(max_dim + 1);
            end
            return w;
        end
    endfunction

endpackage

/* sv/radial_vignette_pixel.sv */
// This is the top level of the quadratic radial vignette. It holds the configuration registers,
// the axis and colour lanes, the pipelined divider and the merging output stage.
// It depends on rvig_pkg, rvig_axis_lane, rvig_divider and rvig_chan_lane.
//
// Usage:
//   A pixel transfers at a rising edge with start high and busy low. Busy is always low,
//   so the block takes one pixel on every clock.
//   Each pixel gives exactly one result. Done is high for one cycle with out_chan_0..2 and
//   alpha_out valid. Pixels leave in arrival order. A pixel passes through two axis stages,
//   one numerator stage, the divider (one entry stage plus one stage per quotient bit,
//   17 in all), the factor stage, the colour lanes and the output register.
//   Configuration transfers on cfg_valid and cfg_ready. cfg_ready is always high.
//   cfg_index selects width (0), height (1) or strength (2). Other indexes are ignored.
//   Write registers only while no pixel is in flight, because the pipeline reads them live.
//   Reset sets width and height to 1, sets strength to 0 (bypass) and drops every pixel in
//   flight. Results cannot be held off by the receiver, so nothing ever stalls.
`timescale 1ns / 1ps

module radial_vignette_pixel #(
    parameter int MAX_DIM = rvig_pkg::MAX_DIM_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [rvig_pkg::COORD_W-1:0]   pix_x,
    input  logic [rvig_pkg::COORD_W-1:0]   pix_y,
    input  logic [rvig_pkg::CHAN_W-1:0]    chan_0,
    input  logic [rvig_pkg::CHAN_W-1:0]    chan_1,
    input  logic [rvig_pkg::CHAN_W-1:0]    chan_2,
    input  logic [rvig_pkg::CHAN_W-1:0]    alpha_in,
    output logic                           done,
    output logic [rvig_pkg::CHAN_W-1:0]    out_chan_0,
    output logic [rvig_pkg::CHAN_W-1:0]    out_chan_1,
    output logic [rvig_pkg::CHAN_W-1:0]    out_chan_2,
    output logic [rvig_pkg::CHAN_W-1:0]    alpha_out,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rvig_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rvig_pkg::CFG_DAT_W-1:0] cfg_data
);

    import rvig_pkg::*;

    localparam int DIM_W      = dim_width(MAX_DIM);
    localparam int DSQ_W      = 2 * DIM_W;
    localparam int DEN_W      = DSQ_W + 1;
    localparam int PROD_W     = STR_W + R2_W;
    localparam int PRE_LAT    = 3;
    localparam int DIV_LAT    = QUO_W + 1;
    localparam int FAC_STAGE  = PRE_LAT + DIV_LAT;
    localparam int SIDE_DEPTH = FAC_STAGE + 2;
    localparam int VLD_DEPTH  = FAC_STAGE + 3;

    // These are the bytes and the bypass flag that ride alongside the arithmetic.
    typedef struct packed {
        logic              bypass;
        logic [CHAN_W-1:0] c0;
        logic [CHAN_W-1:0] c1;
        logic [CHAN_W-1:0] c2;
        logic [CHAN_W-1:0] alpha;
    } side_t;

    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic [STR_W-1:0]     strength_reg;

    logic                 accept;
    logic [VLD_DEPTH-1:0] vld_reg;
    side_t                side_next;
    side_t                side_reg [0:SIDE_DEPTH-1];

    logic [SQ_W-1:0]   sq_x;
    logic [SQ_W-1:0]   sq_y;
    logic [DSQ_W-1:0]  dsq_x;
    logic [DSQ_W-1:0]  dsq_y;
    logic [R2_W-1:0]   r2;
    logic [PROD_W-1:0] prod;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;

    logic [QUO_W-1:0] quo;
    logic             sat;
    logic [FAC_W-1:0] factor_reg;

    logic [CHAN_W-1:0] scaled_0;
    logic [CHAN_W-1:0] scaled_1;
    logic [CHAN_W-1:0] scaled_2;

    logic [CHAN_W-1:0] out_chan_0_reg;
    logic [CHAN_W-1:0] out_chan_1_reg;
    logic [CHAN_W-1:0] out_chan_2_reg;
    logic [CHAN_W-1:0] alpha_out_reg;

    // The pipeline never stalls, so pixels and register writes are always taken.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // These are the configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= CFG_DIM_W'(1);
            height_reg   <= CFG_DIM_W'(1);
            strength_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WIDTH:    width_reg    <= cfg_data[CFG_DIM_W-1:0];
                REG_HEIGHT:   height_reg   <= cfg_data[CFG_DIM_W-1:0];
                REG_STRENGTH: strength_reg <= cfg_data[STR_W-1:0];
                default:      ;
            endcase
        end
    end

    // This valid line marks which pipeline stages hold a pixel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[VLD_DEPTH-2:0], accept};
        end
    end

    // The bytes and the bypass decision follow the pixel down a delay line.
    always_comb
    begin
        side_next.bypass = (strength_reg < BYPASS_BELOW);
        side_next.c0     = chan_0;
        side_next.c1     = chan_1;
        side_next.c2     = chan_2;
        side_next.alpha  = alpha_in;
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int i = 1; i < SIDE_DEPTH; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // The two axis lanes compute the squared offsets and the squared dimensions.
    rvig_axis_lane #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W)
    ) u_axis_x (
        .clk     (clk),
        .pos     (pix_x),
        .dim_cfg (width_reg),
        .mag_sq  (sq_x),
        .dim_sq  (dsq_x)
    );

    rvig_axis_lane #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W)
    ) u_axis_y (
        .clk     (clk),
        .pos     (pix_y),
        .dim_cfg (height_reg),
        .mag_sq  (sq_y),
        .dim_sq  (dsq_y)
    );

    // The numerator stage forms strength * r2 * 16 and the denominator W*W + H*H.
    assign r2   = R2_W'(sq_x) + R2_W'(sq_y);
    assign prod = PROD_W'(strength_reg) * PROD_W'(r2);

    always_ff @(posedge clk)
    begin
        num_reg <= {prod, {STR_SHIFT{1'b0}}};
        den_reg <= DEN_W'(dsq_x) + DEN_W'(dsq_y);
    end

    rvig_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .QUO_W (QUO_W)
    ) u_div (
        .clk (clk),
        .num (num_reg),
        .den (den_reg),
        .quo (quo),
        .sat (sat)
    );

    // The factor is one minus the strength term, and it is held at zero once the term reaches one.
    always_ff @(posedge clk)
    begin
        factor_reg <= sat ? '0 : (FACTOR_ONE - FAC_W'(quo));
    end

    // The three colour lanes scale side by side.
    rvig_chan_lane u_lane_0 (
        .clk    (clk),
        .chan   (side_reg[FAC_STAGE].c0),
        .factor (factor_reg),
        .scaled (scaled_0)
    );

    rvig_chan_lane u_lane_1 (
        .clk    (clk),
        .chan   (side_reg[FAC_STAGE].c1),
        .factor (factor_reg),
        .scaled (scaled_1)
    );

    rvig_chan_lane u_lane_2 (
        .clk    (clk),
        .chan   (side_reg[FAC_STAGE].c2),
        .factor (factor_reg),
        .scaled (scaled_2)
    );

    // The merge stage picks the scaled or the raw bytes and registers the result.
    always_ff @(posedge clk)
    begin
        if (side_reg[FAC_STAGE+1].bypass)
        begin
            out_chan_0_reg <= side_reg[FAC_STAGE+1].c0;
            out_chan_1_reg <= side_reg[FAC_STAGE+1].c1;
            out_chan_2_reg <= side_reg[FAC_STAGE+1].c2;
        end
        else
        begin
            out_chan_0_reg <= scaled_0;
            out_chan_1_reg <= scaled_1;
            out_chan_2_reg <= scaled_2;
        end
        alpha_out_reg <= side_reg[FAC_STAGE+1].alpha;
    end

    assign done       = vld_reg[VLD_DEPTH-1];
    assign out_chan_0 = out_chan_0_reg;
    assign out_chan_1 = out_chan_1_reg;
    assign out_chan_2 = out_chan_2_reg;
    assign alpha_out  = alpha_out_reg;

    // A result appears only for a pixel that transferred exactly one latency earlier.
    a_done_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, VLD_DEPTH)
    ) else $error("result strobe without a matching pixel transfer");

    // Darkening never brightens a channel.
    a_never_brighter: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> (out_chan_0 <= $past(chan_0, VLD_DEPTH)) &&
                 (out_chan_1 <= $past(chan_1, VLD_DEPTH)) &&
                 (out_chan_2 <= $past(chan_2, VLD_DEPTH))
    ) else $error("a scaled channel exceeds its input byte");

    // Alpha stays with its own pixel through the whole pipeline.
    a_alpha_aligned: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> alpha_out == $past(alpha_in, VLD_DEPTH)
    ) else $error("alpha is out of step with its pixel");

endmodule

/* sv/rvig_axis_lane.sv */
// One axis lane of the radial vignette. It clamps the dimension, forms |2*pos - dim| and
// squares both the offset and the dimension over two register stages. It depends on rvig_pkg.
`timescale 1ns / 1ps

module rvig_axis_lane #(
    parameter int MAX_DIM = 4096,
    parameter int DIM_W   = 13
) (
    input  logic                         clk,
    input  logic [rvig_pkg::COORD_W-1:0]   pos,
    input  logic [rvig_pkg::CFG_DIM_W-1:0] dim_cfg,
    output logic [rvig_pkg::SQ_W-1:0]      mag_sq,
    output logic [2*DIM_W-1:0]             dim_sq
);

    import rvig_pkg::*;

    localparam int DSQ_W = 2 * DIM_W;

    logic [DIM_W-1:0] dim_next;
    logic [MAG_W-1:0] twice;
    logic [MAG_W-1:0] dim_ext;
    logic [MAG_W-1:0] mag_next;
    logic [DIM_W-1:0] dim_reg;
    logic [MAG_W-1:0] mag_reg;
    logic [SQ_W-1:0]  mag_sq_reg;
    logic [DSQ_W-1:0] dim_sq_reg;

    // A zero dimension counts as one and an oversize one counts as the maximum.
    always_comb
    begin
        if (dim_cfg == '0)
        begin
            dim_next = DIM_W'(1);
        end
        else if (32'(dim_cfg) > 32'(MAX_DIM))
        begin
            dim_next = DIM_W'(MAX_DIM);
        end
        else
        begin
            dim_next = DIM_W'(dim_cfg);
        end
    end

    // This is the doubled offset from the image center, as a magnitude.
    assign twice    = {pos, 1'b0};
    assign dim_ext  = MAG_W'(dim_next);
    assign mag_next = (twice >= dim_ext) ? (twice - dim_ext) : (dim_ext - twice);

    // The first stage holds the offset and the dimension.
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        dim_reg <= dim_next;
    end

    // The second stage holds both squares.
    always_ff @(posedge clk)
    begin
        mag_sq_reg <= SQ_W'(mag_reg) * SQ_W'(mag_reg);
        dim_sq_reg <= DSQ_W'(dim_reg) * DSQ_W'(dim_reg);
    end

    assign mag_sq = mag_sq_reg;
    assign dim_sq = dim_sq_reg;

endmodule

/* sv/rvig_divider.sv */
// This is a pipelined restoring divider with one quotient bit per stage and a saturation flag.
// It computes num / den and flags a quotient at or above 2**QUO_W. It depends on rvig_pkg.
`timescale 1ns / 1ps

module rvig_divider #(
    parameter int NUM_W = 47,
    parameter int DEN_W = 27,
    parameter int QUO_W = 16
) (
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic             sat
);

    import rvig_pkg::*;

    logic [NUM_W-1:0] rem_reg [0:QUO_W];
    logic [DEN_W-1:0] den_reg [0:QUO_W];
    logic [QUO_W-1:0] quo_reg [0:QUO_W];
    logic             sat_reg [0:QUO_W];

    // The entry stage checks for a quotient too large to fit and loads the remainder.
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num;
        den_reg[0] <= den;
        quo_reg[0] <= '0;
        sat_reg[0] <= (num >= (NUM_W'(den) << QUO_W));
    end

    // Each stage settles one quotient bit, the most significant bit first.
    for (genvar i = 0; i < QUO_W; i++)
    begin : g_stage
        localparam int BIT = QUO_W - 1 - i;

        logic [NUM_W:0]   trial;
        logic [NUM_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        always_comb
        begin
            trial    = {1'b0, rem_reg[i]} - {1'b0, (NUM_W'(den_reg[i]) << BIT)};
            rem_next = rem_reg[i];
            quo_next = quo_reg[i];
            if (!trial[NUM_W])
            begin
                rem_next      = trial[NUM_W-1:0];
                quo_next[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i+1] <= rem_next;
            den_reg[i+1] <= den_reg[i];
            quo_reg[i+1] <= quo_next;
            sat_reg[i+1] <= sat_reg[i];
        end
    end

    assign quo = quo_reg[QUO_W];
    assign sat = sat_reg[QUO_W];

endmodule

/* sv/rvig_chan_lane.sv */
// One colour lane. It scales a channel byte by the Q1.16 vignette factor and truncates it.
// It has one register stage and depends on rvig_pkg.
`timescale 1ns / 1ps

module rvig_chan_lane (
    input  logic                        clk,
    input  logic [rvig_pkg::CHAN_W-1:0] chan,
    input  logic [rvig_pkg::FAC_W-1:0]  factor,
    output logic [rvig_pkg::CHAN_W-1:0] scaled
);

    import rvig_pkg::*;

    localparam int PROD_W = CHAN_W + FAC_W;

    logic [PROD_W-1:0] prod;
    logic [CHAN_W-1:0] scaled_reg;

    // The factor is at most one, so the product shifted right by 16 still fits in a byte.
    assign prod = PROD_W'(chan) * PROD_W'(factor);

    always_ff @(posedge clk)
    begin
        scaled_reg <= prod[FRAC_W+CHAN_W-1:FRAC_W];
    end

    assign scaled = scaled_reg;

endmodule
